[hdl/pts_pkg.sv]
// pts_pkg: shared constants, codes and types of the priority task scheduler
// used by pts_cell and priority_task_scheduler; depends on nothing else
`default_nettype none

package pts_pkg;

   // table size and sleep counter width
   localparam int NUM_TASKS   = 8;
   localparam int TICK_BITS   = 16;

   // derived widths
   localparam int TASK_ID_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int REQ_ID_W    = 3;
   localparam int ID_CMP_W    = (TASK_ID_W > REQ_ID_W) ? TASK_ID_W : REQ_ID_W;
   localparam int SCAN_CNT_W  = $clog2(NUM_TASKS + 1);

   // priority register layout
   localparam int PRIO_W      = 8;
   localparam int PRIO_FIELDS = 8;
   localparam int CFG_W       = PRIO_W * PRIO_FIELDS;

   // stream payload layout
   localparam int MODE_W      = 2;
   localparam int SLEEP_W     = 16;
   localparam int REQ_TUSER_W = MODE_W;
   localparam int REQ_TDATA_W = 24;
   localparam int CUR_W       = 3;
   localparam int UPTIME_W    = 32;
   localparam int RSP_PAD_W   = 4;
   localparam int RSP_TDATA_W = CUR_W + 1 + UPTIME_W + RSP_PAD_W;

   // request kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK     = 2'd0,
      MODE_BLOCK    = 2'd1,
      MODE_READY    = 2'd2,
      MODE_INACTIVE = 2'd3
   } mode_type;

   // per-task status codes
   typedef enum logic [1:0] {
      STAT_INACTIVE = 2'd0,
      STAT_READY    = 2'd1,
      STAT_BLOCKED  = 2'd2
   } task_status_type;

   // sequencer states
   typedef enum logic {
      SCHED_IDLE,
      SCHED_SCAN
   } sched_state_type;

   // best-so-far candidate passed from cell to cell
   typedef struct packed {
      logic                 found;
      logic [PRIO_W-1:0]    prio;
      logic [TASK_ID_W-1:0] idx;
   } scan_token_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                 tick;
      logic                 write;
      mode_type             mode;
      logic [REQ_ID_W-1:0]  task_id;
      logic [TICK_BITS-1:0] count;
   } cell_cmd_type;

endpackage

`default_nettype wire

[hdl/pts_cell.sv]
// pts_cell: one task slot holding status and sleep count, plus one stage of
// the registered selection chain; depends on pts_pkg
`default_nettype none

module pts_cell import pts_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_cmd_type         cmd,
   input  wire logic [TASK_ID_W-1:0] cell_idx,
   input  wire logic [PRIO_W-1:0]    prio,
   input  wire scan_token_type       token_in,
   output scan_token_type            token_out
);

   task_status_type      status_ff, status_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;
   scan_token_type       pick_ff, pick_in;
   logic                 id_hit;
   logic                 take;

   assign id_hit = (ID_CMP_W'(cmd.task_id) == ID_CMP_W'(cell_idx));

   // status and sleep count update
   always_comb begin
      status_in = status_ff;
      ticks_in  = ticks_ff;
      if (cmd.tick) begin
         if (status_ff == STAT_BLOCKED) begin
            if (ticks_ff != '0) begin
               ticks_in = ticks_ff - 1'b1;
            end
            if (ticks_in == '0) begin
               status_in = STAT_READY;
            end
         end
      end else if (cmd.write && id_hit) begin
         unique case (cmd.mode)
            MODE_BLOCK: begin
               status_in = STAT_BLOCKED;
               ticks_in  = cmd.count;
            end
            MODE_READY:    status_in = STAT_READY;
            MODE_INACTIVE: status_in = STAT_INACTIVE;
            default:       status_in = status_ff;
         endcase
      end
   end

   // selection stage: strictly higher priority replaces, so lower index wins ties
   assign take = (status_ff == STAT_READY) && (!token_in.found || (prio > token_in.prio));

   always_comb begin
      pick_in = token_in;
      if (take) begin
         pick_in.found = 1'b1;
         pick_in.prio  = prio;
         pick_in.idx   = cell_idx;
      end
   end

   // task state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= STAT_INACTIVE;
         ticks_ff  <= '0;
      end else begin
         status_ff <= status_in;
         ticks_ff  <= ticks_in;
      end
   end

   // chain stage register, refreshed every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         pick_ff <= '0;
      end else begin
         pick_ff <= pick_in;
      end
   end

   assign token_out = pick_ff;

endmodule

`default_nettype wire

[hdl/priority_task_scheduler.sv]
// priority_task_scheduler: top level with sequencer, uptime counter, result
// register and the row of task cells; depends on pts_pkg and pts_cell
//
//  channel  direction  ports                          request
//  req      in         req_tvalid/tready/tdata/tuser  task command or tick
//  rsp      out        rsp_tvalid/tready/tdata        current task, ready flag, uptime
//  csr      in         csr_valid/ready/wdata          task priority register write
//
// a block, ready or inactive request gives its response in the cycle after accept
// a tick first updates the cells, then the selection token ripples through
// the registered cell chain one cell per cycle before the response loads
// one request is in flight at a time; req_tready drops during a tick's scan
// a stalled response holds off the next request; csr is always ready
// synchronous active-high reset clears all tasks to inactive, counts to zero
`default_nettype none

module priority_task_scheduler import pts_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // task_id[2:0], sleep_count[18:3], zeros
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,  // mode[1:0]
   // response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // cur_task[2:0], any_ready[3],
                                                   // uptime[35:4], zeros
   // priority register write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CFG_W-1:0]       csr_wdata
);

   sched_state_type         state_ff, state_in;
   logic [SCAN_CNT_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [CFG_W-1:0]        prio_cfg_ff;
   logic [CUR_W-1:0]        running_ff, running_in;
   logic                    ready_seen_ff, ready_seen_in;
   logic [UPTIME_W-1:0]     uptime_ff, uptime_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic                    req_accept;
   logic                    tick_accept;
   logic                    write_accept;
   logic                    rsp_free;
   logic                    scan_done;
   logic                    done_load;
   mode_type                req_mode;
   cell_cmd_type            cell_cmd;
   scan_token_type          chain [NUM_TASKS+1];
   scan_token_type          best;
   logic [PRIO_W-1:0]       cell_prio [NUM_TASKS];

   // request decode
   assign req_mode     = mode_type'(req_tuser[MODE_W-1:0]);
   assign req_accept   = req_tvalid && req_tready;
   assign tick_accept  = req_accept && (req_mode == MODE_TICK);
   assign write_accept = req_accept && (req_mode != MODE_TICK);
   assign rsp_free     = !rsp_tvalid_ff || rsp_tready;
   assign scan_done    = (scan_cnt_ff == SCAN_CNT_W'(NUM_TASKS));

   // command broadcast to the cells
   always_comb begin
      cell_cmd.tick    = tick_accept;
      cell_cmd.write   = write_accept;
      cell_cmd.mode    = req_mode;
      cell_cmd.task_id = req_tdata[REQ_ID_W-1:0];
      cell_cmd.count   = TICK_BITS'(req_tdata[REQ_ID_W+SLEEP_W-1:REQ_ID_W]);
   end

   // row of task cells, token enters empty at cell 0
   assign chain[0] = '0;

   for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
      if (i < PRIO_FIELDS) begin : g_prio
         assign cell_prio[i] = prio_cfg_ff[i*PRIO_W +: PRIO_W];
      end else begin : g_noprio
         assign cell_prio[i] = '0;
      end

      pts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cell_cmd),
         .cell_idx  (TASK_ID_W'(i)),
         .prio      (cell_prio[i]),
         .token_in  (chain[i]),
         .token_out (chain[i+1])
      );
   end

   assign best = chain[NUM_TASKS];

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SCHED_IDLE: begin
            if (tick_accept) begin
               state_in = SCHED_SCAN;
            end
         end
         SCHED_SCAN: begin
            if (scan_done && rsp_free) begin
               state_in = SCHED_IDLE;
            end
         end
         default: state_in = SCHED_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      done_load   = 1'b0;
      scan_cnt_in = '0;
      unique case (state_ff)
         SCHED_IDLE: begin
            req_tready = rsp_free;
         end
         SCHED_SCAN: begin
            done_load   = scan_done && rsp_free;
            scan_cnt_in = scan_done ? scan_cnt_ff : scan_cnt_ff + 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // scheduler state and response next values
   always_comb begin
      uptime_in     = tick_accept ? uptime_ff + 1'b1 : uptime_ff;
      running_in    = done_load ? CUR_W'(best.idx) : running_ff;
      ready_seen_in = done_load ? best.found : ready_seen_ff;

      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (write_accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{RSP_PAD_W{1'b0}}, uptime_ff, ready_seen_ff, running_ff};
      end else if (done_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{RSP_PAD_W{1'b0}}, uptime_ff, best.found, CUR_W'(best.idx)};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SCHED_IDLE;
         scan_cnt_ff   <= '0;
         running_ff    <= '0;
         ready_seen_ff <= 1'b0;
         uptime_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
         prio_cfg_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         running_ff    <= running_in;
         ready_seen_ff <= ready_seen_in;
         uptime_ff     <= uptime_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            prio_cfg_ff <= csr_wdata;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // checks
   a_write_rsp_next: assert property (@(posedge clock) disable iff (reset)
      write_accept |=> (rsp_tvalid && $stable(uptime_ff)))
      else $error("task command did not respond in the next cycle");

   a_tick_uptime: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> (uptime_ff == UPTIME_W'($past(uptime_ff) + 1'b1)))
      else $error("uptime did not advance on tick");

   a_idle_task_zero: assert property (@(posedge clock) disable iff (reset)
      !ready_seen_ff |-> (running_ff == '0))
      else $error("current task nonzero with no ready task");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCHED_SCAN) |-> (scan_cnt_ff <= SCAN_CNT_W'(NUM_TASKS)) && !req_tready)
      else $error("scan counter overran or request taken during scan");

endmodule

`default_nettype wire
